// File: rtl/tsq_pkg.sv
// shared types and constants of the touch strip qualifier
package tsq_pkg;

  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 64;
  localparam int COUNT_W  = 8;
  localparam int INDEX_W  = 3;
  localparam int CFG_W    = 12;
  localparam int DATA_W   = 80;

  // phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_TRACK = 2'd2;
  localparam logic [1:0] PH_HOLD  = 2'd3;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_THRESHOLD = 3'd0;
  localparam logic [INDEX_W-1:0] REG_JUMP      = 3'd1;
  localparam logic [INDEX_W-1:0] REG_IDLE      = 3'd2;
  localparam logic [INDEX_W-1:0] REG_START     = 3'd3;
  localparam logic [INDEX_W-1:0] REG_HOLD      = 3'd4;
  localparam logic [INDEX_W-1:0] REG_RELEASE   = 3'd5;

  // register reset values
  localparam logic [SAMPLE_W-1:0] RST_THRESHOLD = 12'd50;
  localparam logic [SAMPLE_W-1:0] RST_JUMP      = 12'd200;
  localparam logic [COUNT_W-1:0]  RST_IDLE      = 8'd20;
  localparam logic [COUNT_W-1:0]  RST_START     = 8'd100;
  localparam logic [COUNT_W-1:0]  RST_HOLD      = 8'd80;
  localparam logic [SAMPLE_W-1:0] RST_RELEASE   = 12'd2048;
  localparam logic [COUNT_W-1:0]  RST_COUNT     = 8'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] threshold;
    logic [SAMPLE_W-1:0] jump_limit;
    logic [COUNT_W-1:0]  idle_interval;
    logic [COUNT_W-1:0]  start_delay;
    logic [COUNT_W-1:0]  hold_interval;
    logic [SAMPLE_W-1:0] release_code;
  } cfg_t;

  typedef struct packed {
    logic                emit;
    logic                is_release;
    logic [SAMPLE_W-1:0] position;
  } result_t;

endpackage

// File: rtl/tsq_cfg_regs.sv
// configuration register file of the touch strip qualifier
module tsq_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [tsq_pkg::INDEX_W-1:0] cfg_index,
  input  logic [tsq_pkg::CFG_W-1:0]   cfg_wdata,
  output tsq_pkg::cfg_t               cfg
);

  tsq_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold     <= tsq_pkg::RST_THRESHOLD;
      cfg_r.jump_limit    <= tsq_pkg::RST_JUMP;
      cfg_r.idle_interval <= tsq_pkg::RST_IDLE;
      cfg_r.start_delay   <= tsq_pkg::RST_START;
      cfg_r.hold_interval <= tsq_pkg::RST_HOLD;
      cfg_r.release_code  <= tsq_pkg::RST_RELEASE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsq_pkg::REG_THRESHOLD: cfg_r.threshold     <= cfg_wdata;
        tsq_pkg::REG_JUMP:      cfg_r.jump_limit    <= cfg_wdata;
        tsq_pkg::REG_IDLE:      cfg_r.idle_interval <= cfg_wdata[tsq_pkg::COUNT_W-1:0];
        tsq_pkg::REG_START:     cfg_r.start_delay   <= cfg_wdata[tsq_pkg::COUNT_W-1:0];
        tsq_pkg::REG_HOLD:      cfg_r.hold_interval <= cfg_wdata[tsq_pkg::COUNT_W-1:0];
        tsq_pkg::REG_RELEASE:   cfg_r.release_code  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/tsq_core.sv
// decimation counter, phase machine and jump check of the touch strip qualifier
module tsq_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [tsq_pkg::SAMPLE_W-1:0] sample,
  input  tsq_pkg::cfg_t                cfg,
  output tsq_pkg::result_t             result
);

  logic [1:0]                   phase_r, phase_nxt;
  logic [tsq_pkg::COUNT_W-1:0]  count_r, count_nxt, count_dec;
  logic [tsq_pkg::SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [tsq_pkg::SAMPLE_W-1:0] diff;
  logic                         evaluate;
  logic                         below;

  assign count_dec = count_r - 1'b1;
  assign evaluate  = (count_dec == '0);
  assign below     = (sample < cfg.threshold);
  // true absolute difference against the last evaluated sample
  assign diff      = (sample >= prev_r) ? (sample - prev_r) : (prev_r - sample);

  always_comb begin
    phase_nxt         = phase_r;
    count_nxt         = count_dec;
    prev_nxt          = prev_r;
    result.emit       = 1'b0;
    result.is_release = 1'b0;
    result.position   = sample;
    if (evaluate) begin
      count_nxt = cfg.idle_interval;
      prev_nxt  = sample;
      unique case (phase_r)
        tsq_pkg::PH_IDLE: begin
          if (!below) begin
            phase_nxt = tsq_pkg::PH_START;
            count_nxt = cfg.start_delay;
          end
        end
        tsq_pkg::PH_START: begin
          phase_nxt = below ? tsq_pkg::PH_IDLE : tsq_pkg::PH_TRACK;
        end
        tsq_pkg::PH_TRACK: begin
          result.emit = (diff < cfg.jump_limit) && (sample > cfg.threshold);
          phase_nxt   = tsq_pkg::PH_HOLD;
          count_nxt   = cfg.hold_interval;
        end
        default: begin
          if (below) begin
            result.emit       = 1'b1;
            result.is_release = 1'b1;
            result.position   = cfg.release_code;
            phase_nxt         = tsq_pkg::PH_IDLE;
          end else begin
            phase_nxt = tsq_pkg::PH_TRACK;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tsq_pkg::PH_IDLE;
      count_r <= tsq_pkg::RST_COUNT;
      prev_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

// File: rtl/touch_strip_qualifier.sv
// top level of the touch strip qualifier
// path: a sample request is held in the input register and its result in the result register
// throughput: one sample request per cycle while the result side keeps up
// the rate is set by the input register feeding the result register in one pass
// reset: synchronous, active low; clears the pipeline, phase machine and previous
// sample, presets the countdown and reloads every configuration register with its default
module touch_strip_qualifier (
  input  logic                        clk,
  input  logic                        rst_n,
  // sample requests
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [tsq_pkg::DATA_W-1:0]  in_tdata,   // sample[11:0], timestamp[75:12], zero fill
  // result requests
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tsq_pkg::DATA_W-1:0]  out_tdata,  // position[11:0], event_time[75:12], zero fill
  output logic                        out_tuser,  // is_release
  // configuration writes
  input  logic                        cfg_we,
  input  logic [tsq_pkg::INDEX_W-1:0] cfg_index,
  input  logic [tsq_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int TIME_LO = tsq_pkg::SAMPLE_W;
  localparam int TIME_HI = tsq_pkg::SAMPLE_W + tsq_pkg::TIME_W - 1;
  localparam int FILL_W  = tsq_pkg::DATA_W - tsq_pkg::SAMPLE_W - tsq_pkg::TIME_W;

  tsq_pkg::cfg_t    cfg;
  tsq_pkg::result_t result;

  // input register
  logic                         in_valid_r;
  logic [tsq_pkg::SAMPLE_W-1:0] in_sample_r;
  logic [tsq_pkg::TIME_W-1:0]   in_time_r;

  // result register
  logic                         out_valid_r;
  logic                         out_release_r;
  logic [tsq_pkg::SAMPLE_W-1:0] out_pos_r;
  logic [tsq_pkg::TIME_W-1:0]   out_time_r;

  logic advance;
  logic in_take;

  // the registered sample moves on once the result register is free or draining;
  // skipped samples and samples with no result just retire here
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_sample_r <= in_tdata[tsq_pkg::SAMPLE_W-1:0];
      in_time_r   <= in_tdata[TIME_HI:TIME_LO];
    end
  end

  tsq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // state only moves when the registered sample is retired
  tsq_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .sample (in_sample_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_release_r <= result.is_release;
      out_pos_r     <= result.position;
      out_time_r    <= in_time_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_release_r;
  assign out_tdata  = {{FILL_W{1'b0}}, out_time_r, out_pos_r};

endmodule

// File: rtl/tsq_checker.sv
// port checker of the touch strip qualifier and its bind
module tsq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [tsq_pkg::DATA_W-1:0]  out_tdata,
  input logic                        out_tuser
);

  localparam int USED_W = tsq_pkg::SAMPLE_W + tsq_pkg::TIME_W;

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // no result is offered and samples can be accepted right after reset is released
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid && in_tready)
    else $error("pipeline not empty after reset");

  // a new result needs a sample accepted earlier
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !$past(out_tvalid) |-> $past(in_tready, 1) || !$past(in_tvalid, 2)
      || $past(in_tready, 2))
    else $error("result appeared without a sample");

  // fill bits of the result are zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[tsq_pkg::DATA_W-1:USED_W] == '0)
    else $error("result fill bits not zero");

endmodule

bind touch_strip_qualifier tsq_checker u_tsq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
